>>> src/bcs_pkg.sv
// Shared types and constants for the B-spline charge spreading core.
`default_nettype none

package bcs_pkg;

    // Fixed field widths
    localparam int IDX_W   = 7;   // grid index, enough for the largest grid
    localparam int K_W     = 8;   // axis size, holds the largest grid size itself
    localparam int W_W     = 24;  // spline weight, unsigned Q.24
    localparam int Q_W     = 24;  // charge, signed Q8.16
    localparam int CFG_W   = 63;  // packed configuration word
    localparam int COORD_W = 21;  // one packed component

    // 1/3 reciprocal, exact floor division for 32-bit operands with a 33-bit shift
    localparam logic [31:0] RECIP3 = 32'hAAAAAAAB;

    typedef enum logic [1:0] {
        ACT_CLEAR   = 2'd0,
        ACT_DEPOSIT = 2'd1,
        ACT_READ    = 2'd2,
        ACT_NOP     = 2'd3
    } action_t;

    // Configuration register indexes
    localparam logic [2:0] REG_ORIGIN = 3'd0;
    localparam logic [2:0] REG_ROW_A  = 3'd1;
    localparam logic [2:0] REG_ROW_B  = 3'd2;
    localparam logic [2:0] REG_ROW_C  = 3'd3;
    localparam logic [2:0] REG_SIZE_A = 3'd4;
    localparam logic [2:0] REG_SIZE_B = 3'd5;
    localparam logic [2:0] REG_SIZE_C = 3'd6;

    // Configuration as seen by the front end; sizes already clamped
    typedef struct packed {
        logic [CFG_W-1:0]          origin;
        logic [2:0][CFG_W-1:0]     row;
        logic [2:0][K_W-1:0]       size;
    } cfg_t;

    // Classified command passed from front to back
    typedef struct packed {
        action_t                   act;
        logic                      status;
        logic signed [Q_W-1:0]     q;
        logic [2:0][IDX_W-1:0]     pt;    // top point per axis, or read index
        logic [2:0][K_W-1:0]       size;
        logic [2:0][3:0][W_W-1:0]  w;     // weights for points pt-3..pt
    } cmd_t;

    typedef enum logic [3:0] {
        F_IDLE,
        F_PROJ,
        F_SCALE,
        F_WRAP,
        F_POW,
        F_POW3,
        F_POLY,
        F_DIV,
        F_PUSH
    } front_state_t;

    typedef enum logic [2:0] {
        B_CLEAR,
        B_IDLE,
        B_DEPOSIT,
        B_DRAIN,
        B_READ
    } back_state_t;

endpackage

`default_nettype wire

>>> src/bspline_charge_spreading_core.sv
// Top level of the cubic B-spline charge spreading core.
// Spreads charges onto a periodic GRID_MAX^3 grid of 40-bit saturating
// accumulators, clears it, and reads single points. In the front end a
// deposit uses one shared projection multiplier for nine products, then
// six steps per axis for the spline weights. The back end performs its 64
// read-modify-write updates at one per cycle through the separate read and
// write ports of the grid memory; the two ends overlap through a two-entry
// command queue. An in-range read goes through the grid memory read register
// and the result register; one out of range returns zero with status set. A
// clear, and the clearing pass right after reset, write zero to
// 2^(3*clog2(GRID_MAX)) entries one per cycle (32768 at the default);
// transactions are queued meanwhile, configuration writes are always taken.
`default_nettype none

module bspline_charge_spreading_core #(
    parameter int GRID_MAX = 32
) (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                s_valid,
    output logic                     s_ready,
    input  wire logic [1:0]          s_action,
    input  wire logic signed [31:0]  s_pos_x,
    input  wire logic signed [31:0]  s_pos_y,
    input  wire logic signed [31:0]  s_pos_z,
    input  wire logic signed [23:0]  s_charge,
    input  wire logic [4:0]          s_read_a,
    input  wire logic [4:0]          s_read_b,
    input  wire logic [4:0]          s_read_c,
    output logic                     m_valid,
    input  wire logic                m_ready,
    output logic signed [39:0]       m_grid_value,
    output logic                     m_status,
    input  wire logic                cfg_valid,
    output logic                     cfg_ready,
    input  wire logic [2:0]          cfg_index,
    input  wire logic [62:0]         cfg_data
);
    import bcs_pkg::*;

    logic [CFG_W-1:0]      origin_reg;
    logic [2:0][CFG_W-1:0] row_reg;
    logic [2:0][5:0]       size_reg;
    cfg_t                  cfg;

    logic  q_in_valid, q_in_ready, q_out_valid, q_pop;
    cmd_t  q_in_cmd, q_out_cmd;

    assign cfg_ready = 1'b1;

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            origin_reg <= '0;
            row_reg    <= '0;
            size_reg   <= {3{6'd32}};
        end else if (cfg_valid) begin
            case (cfg_index)
                REG_ORIGIN: origin_reg  <= cfg_data;
                REG_ROW_A:  row_reg[0]  <= cfg_data;
                REG_ROW_B:  row_reg[1]  <= cfg_data;
                REG_ROW_C:  row_reg[2]  <= cfg_data;
                REG_SIZE_A: size_reg[0] <= cfg_data[5:0];
                REG_SIZE_B: size_reg[1] <= cfg_data[5:0];
                REG_SIZE_C: size_reg[2] <= cfg_data[5:0];
                default: ;
            endcase
        end
    end

    // Axis sizes clamped into 4..GRID_MAX
    always_comb begin
        cfg.origin = origin_reg;
        cfg.row    = row_reg;
        for (int i = 0; i < 3; i++) begin
            if (K_W'(size_reg[i]) < K_W'(4)) begin
                cfg.size[i] = K_W'(4);
            end else if (K_W'(size_reg[i]) > K_W'(GRID_MAX)) begin
                cfg.size[i] = K_W'(GRID_MAX);
            end else begin
                cfg.size[i] = K_W'(size_reg[i]);
            end
        end
    end

    bcs_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg        (cfg),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_action   (s_action),
        .s_pos_x    (s_pos_x),
        .s_pos_y    (s_pos_y),
        .s_pos_z    (s_pos_z),
        .s_charge   (s_charge),
        .s_read_a   (s_read_a),
        .s_read_b   (s_read_b),
        .s_read_c   (s_read_c),
        .push_valid (q_in_valid),
        .push_ready (q_in_ready),
        .push_cmd   (q_in_cmd)
    );

    bcs_cmd_fifo u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (q_in_valid),
        .in_ready  (q_in_ready),
        .in_cmd    (q_in_cmd),
        .out_valid (q_out_valid),
        .out_pop   (q_pop),
        .out_cmd   (q_out_cmd)
    );

    bcs_back #(
        .GRID_MAX (GRID_MAX)
    ) u_back (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cmd_valid    (q_out_valid),
        .cmd_pop      (q_pop),
        .cmd_head     (q_out_cmd),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_grid_value (m_grid_value),
        .m_status     (m_status)
    );

endmodule

`default_nettype wire

>>> src/bcs_front.sv
// Front end: accepts transactions, projects positions and builds spline weights.
`default_nettype none

module bcs_front (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire bcs_pkg::cfg_t                 cfg,
    input  wire logic                          s_valid,
    output logic                               s_ready,
    input  wire logic [1:0]                    s_action,
    input  wire logic signed [31:0]            s_pos_x,
    input  wire logic signed [31:0]            s_pos_y,
    input  wire logic signed [31:0]            s_pos_z,
    input  wire logic signed [23:0]            s_charge,
    input  wire logic [4:0]                    s_read_a,
    input  wire logic [4:0]                    s_read_b,
    input  wire logic [4:0]                    s_read_c,
    output logic                               push_valid,
    input  wire logic                          push_ready,
    output bcs_pkg::cmd_t                      push_cmd
);
    import bcs_pkg::*;

    front_state_t state_reg, state_next;
    logic [1:0]   axis_reg;
    logic [1:0]   term_reg;
    cmd_t         cmd_reg;

    logic [2:0][32:0] p_reg;
    logic [35:0]      acc_reg;
    logic [43:0]      x_reg;
    logic [15:0]      f_reg;
    logic [31:0]      f2_reg;
    logic [16:0]      g_reg;
    logic [33:0]      g2_reg;
    logic [47:0]      f3_reg;
    logic [50:0]      g3_reg;
    logic [3:0][26:0] y_reg;

    logic               accept;
    logic [2:0][32:0]   p_in;
    logic [2:0][31:0]   pos_in;
    logic signed [20:0] coef;
    logic signed [53:0] proj;
    logic [K_W-1:0]     k_sel;
    logic [43:0]        scaled;
    logic [43:0]        lim;
    logic [43:0]        wrapped;
    logic [16:0]        g_in;
    logic signed [52:0] sf3, sf2s, sf1s;
    logic [3:0][52:0]   n_val;
    logic [3:0][52:0]   n_rnd;
    logic [3:0][58:0]   dprod;

    assign accept     = s_valid && s_ready;
    assign s_ready    = (state_reg == F_IDLE);
    assign push_valid = (state_reg == F_PUSH);
    assign push_cmd   = cmd_reg;

    // Position relative to the origin, Q.16, 33 bits
    assign pos_in = {s_pos_z, s_pos_y, s_pos_x};
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            p_in[i] = {pos_in[i][31], pos_in[i]}
                    - {{4{cfg.origin[COORD_W*i+COORD_W-1]}},
                       cfg.origin[COORD_W*i +: COORD_W], 8'b0};
        end
    end

    // One projection term per cycle, kept modulo one period of the fractional coordinate (Q.36)
    assign coef = $signed(cfg.row[axis_reg][COORD_W*term_reg +: COORD_W]);
    assign proj = $signed(p_reg[term_reg]) * coef;

    // Scale to grid units, add two cells, wrap once
    assign k_sel   = cfg.size[axis_reg];
    assign scaled  = 44'(k_sel) * 44'(acc_reg) + (44'd1 << 37);
    assign lim     = {k_sel, 36'b0};
    assign wrapped = (x_reg >= lim) ? (x_reg - lim) : x_reg;
    assign g_in    = 17'h10000 - {1'b0, f_reg};

    // Cubic B-spline numerators, Q.48 scaled by six
    always_comb begin
        sf3  = $signed({5'b0, f3_reg});
        sf2s = $signed({5'b0, f2_reg, 16'b0});
        sf1s = $signed({5'b0, f_reg, 32'b0});
        n_val[0] = {2'b0, g3_reg};
        n_val[1] = 53'(53'sd3 * sf3 - 53'sd6 * sf2s + (53'sd4 <<< 48));
        n_val[2] = 53'(sf1s * 53'sd3 + 53'sd3 * sf2s - 53'sd3 * sf3 + (53'sd1 <<< 48));
        n_val[3] = 53'(sf3);
        for (int i = 0; i < 4; i++) begin
            n_rnd[i] = n_val[i] + (53'd3 << 24);
        end
    end

    // Final divide by three through the reciprocal
    always_comb begin
        for (int i = 0; i < 4; i++) begin
            dprod[i] = 59'(y_reg[i]) * 59'(RECIP3);
        end
    end

    // State register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= F_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            F_IDLE: begin
                if (accept) begin
                    case (action_t'(s_action))
                        ACT_DEPOSIT: state_next = F_PROJ;
                        ACT_CLEAR:   state_next = F_PUSH;
                        ACT_READ:    state_next = F_PUSH;
                        default:     state_next = F_IDLE;
                    endcase
                end
            end
            F_PROJ:  if (term_reg == 2'd2) state_next = F_SCALE;
            F_SCALE: state_next = F_WRAP;
            F_WRAP:  state_next = F_POW;
            F_POW:   state_next = F_POW3;
            F_POW3:  state_next = F_POLY;
            F_POLY:  state_next = F_DIV;
            F_DIV:   state_next = (axis_reg == 2'd2) ? F_PUSH : F_PROJ;
            F_PUSH:  if (push_ready) state_next = F_IDLE;
            default: state_next = F_IDLE;
        endcase
    end

    // Datapath registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            axis_reg <= 2'd0;
            term_reg <= 2'd0;
        end else begin
            case (state_reg)
                F_IDLE: begin
                    if (accept) begin
                        axis_reg       <= 2'd0;
                        term_reg       <= 2'd0;
                        acc_reg        <= '0;
                        p_reg          <= p_in;
                        cmd_reg.act    <= action_t'(s_action);
                        cmd_reg.q      <= s_charge;
                        cmd_reg.size   <= cfg.size;
                        cmd_reg.pt[0]  <= IDX_W'(s_read_a);
                        cmd_reg.pt[1]  <= IDX_W'(s_read_b);
                        cmd_reg.pt[2]  <= IDX_W'(s_read_c);
                        cmd_reg.status <= (K_W'(s_read_a) >= cfg.size[0])
                                       || (K_W'(s_read_b) >= cfg.size[1])
                                       || (K_W'(s_read_c) >= cfg.size[2]);
                    end
                end
                F_PROJ: begin
                    acc_reg  <= acc_reg + proj[35:0];
                    term_reg <= term_reg + 2'd1;
                end
                F_SCALE: x_reg <= scaled;
                F_WRAP: begin
                    cmd_reg.pt[axis_reg] <= wrapped[42:36];
                    f_reg                <= wrapped[35:20];
                end
                F_POW: begin
                    f2_reg <= f_reg * f_reg;
                    g_reg  <= g_in;
                    g2_reg <= 34'(g_in) * 34'(g_in);
                end
                F_POW3: begin
                    f3_reg <= 48'(f2_reg) * 48'(f_reg);
                    g3_reg <= 51'(g2_reg) * 51'(g_reg);
                end
                F_POLY: begin
                    for (int i = 0; i < 4; i++) begin
                        y_reg[i] <= n_rnd[i][51:25];
                    end
                end
                F_DIV: begin
                    for (int i = 0; i < 4; i++) begin
                        cmd_reg.w[axis_reg][i] <= dprod[i][56:33];
                    end
                    axis_reg <= axis_reg + 2'd1;
                    term_reg <= 2'd0;
                    acc_reg  <= '0;
                end
                default: ;
            endcase
        end
    end

endmodule

`default_nettype wire

>>> src/bcs_cmd_fifo.sv
// Two-entry command queue between the front and back ends.
`default_nettype none

module bcs_cmd_fifo (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           in_valid,
    output logic                in_ready,
    input  wire bcs_pkg::cmd_t  in_cmd,
    output logic                out_valid,
    input  wire logic           out_pop,
    output bcs_pkg::cmd_t       out_cmd
);
    import bcs_pkg::*;

    cmd_t       mem_reg [2];
    logic       wr_ptr_reg, rd_ptr_reg;
    logic [1:0] count_reg;
    logic       do_push, do_pop;

    assign in_ready  = (count_reg != 2'd2);
    assign out_valid = (count_reg != 2'd0);
    assign out_cmd   = mem_reg[rd_ptr_reg];
    assign do_push   = in_valid && in_ready;
    assign do_pop    = out_pop && out_valid;

    // Storage
    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= in_cmd;
        end
    end

    // Pointers and fill level
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            if (do_push) wr_ptr_reg <= ~wr_ptr_reg;
            if (do_pop)  rd_ptr_reg <= ~rd_ptr_reg;
            case ({do_push, do_pop})
                2'b10:   count_reg <= count_reg + 2'd1;
                2'b01:   count_reg <= count_reg - 2'd1;
                default: count_reg <= count_reg;
            endcase
        end
    end

endmodule

`default_nettype wire

>>> src/bcs_back.sv
// Back end: grid memory, clearing sweep, 64-point deposit pipeline and reads.
`default_nettype none

module bcs_back #(
    parameter int GRID_MAX = 32
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 cmd_valid,
    output logic                      cmd_pop,
    input  wire bcs_pkg::cmd_t        cmd_head,
    output logic                      m_valid,
    input  wire logic                 m_ready,
    output logic signed [39:0]        m_grid_value,
    output logic                      m_status
);
    import bcs_pkg::*;

    localparam int AW    = $clog2(GRID_MAX);
    localparam int MW    = 3 * AW;
    localparam int DEPTH = 1 << MW;

    logic [39:0] grid_mem [DEPTH];
    logic [39:0] rdata_reg;

    back_state_t state_reg, state_next;
    logic [MW-1:0] clr_reg, clr_next;
    logic [5:0]    cnt_reg, cnt_next;
    cmd_t          cmd_reg;

    // Deposit pipeline stages
    logic              v1_reg, v2_reg, v3_reg;
    logic [32:0]       t1_reg, t2_reg, t3_reg;
    logic [MW-1:0]     a1_reg, a2_reg, a3_reg;
    logic [W_W-1:0]    wy1_reg, wz1_reg, wz2_reg;

    logic              m_valid_reg, m_valid_next;
    logic [39:0]       m_value_reg, m_value_next;
    logic              m_status_reg, m_status_next;

    logic              stage0;
    logic [2:0][1:0]   off;
    logic [2:0][AW-1:0] idx;
    logic [MW-1:0]     addr0, rd_addr, wr_addr, head_addr;
    logic              wr_en;
    logic [39:0]       wr_data;
    logic signed [49:0] p1;
    logic signed [58:0] p2, p3;
    logic signed [40:0] sum;
    logic [39:0]       sat;

    assign m_valid      = m_valid_reg;
    assign m_grid_value = m_value_reg;
    assign m_status     = m_status_reg;
    assign stage0       = (state_reg == B_DEPOSIT);

    // Point indices with periodic wrap: pt-3+off, plus size when negative
    assign off = {cnt_reg[1:0], cnt_reg[3:2], cnt_reg[5:4]};
    always_comb begin
        logic [K_W:0] s;
        for (int i = 0; i < 3; i++) begin
            s = (K_W+1)'(cmd_reg.pt[i]) + (K_W+1)'(off[i]);
            if (s < (K_W+1)'(3)) begin
                s = s + (K_W+1)'(cmd_reg.size[i]) - (K_W+1)'(3);
            end else begin
                s = s - (K_W+1)'(3);
            end
            idx[i] = s[AW-1:0];
        end
    end
    assign addr0     = {idx[0], idx[1], idx[2]};
    assign head_addr = {cmd_head.pt[0][AW-1:0], cmd_head.pt[1][AW-1:0],
                        cmd_head.pt[2][AW-1:0]};

    // Weight products, each rounded half up to Q.24
    assign p1 = 50'(cmd_reg.q * $signed({1'b0, cmd_reg.w[0][cnt_reg[5:4]]}))
              + 50'sd32768;
    assign p2 = 59'($signed(t1_reg) * $signed({1'b0, wy1_reg})) + (59'sd1 <<< 23);
    assign p3 = 59'($signed(t2_reg) * $signed({1'b0, wz2_reg})) + (59'sd1 <<< 23);

    // Saturating accumulate
    assign sum = $signed({rdata_reg[39], rdata_reg}) + 41'($signed(t3_reg));
    always_comb begin
        if (sum[40] != sum[39]) begin
            sat = sum[40] ? {1'b1, 39'b0} : {1'b0, {39{1'b1}}};
        end else begin
            sat = sum[39:0];
        end
    end

    // Memory port muxing
    assign rd_addr = v2_reg ? a2_reg : head_addr;
    assign wr_en   = v3_reg || (state_reg == B_CLEAR);
    assign wr_addr = v3_reg ? a3_reg : clr_reg;
    assign wr_data = v3_reg ? sat : 40'd0;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            grid_mem[wr_addr] <= wr_data;
        end
        rdata_reg <= grid_mem[rd_addr];
    end

    // Sequencer registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= B_CLEAR;
            clr_reg      <= '0;
            cnt_reg      <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            clr_reg      <= clr_next;
            cnt_reg      <= cnt_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_value_reg  <= m_value_next;
        m_status_reg <= m_status_next;
        if (cmd_pop) begin
            cmd_reg <= cmd_head;
        end
    end

    // Pipeline valids and payload
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else begin
            v1_reg <= stage0;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge aclk) begin
        t1_reg  <= p1[48:16];
        a1_reg  <= addr0;
        wy1_reg <= cmd_reg.w[1][cnt_reg[3:2]];
        wz1_reg <= cmd_reg.w[2][cnt_reg[1:0]];
        t2_reg  <= p2[56:24];
        a2_reg  <= a1_reg;
        wz2_reg <= wz1_reg;
        t3_reg  <= p3[56:24];
        a3_reg  <= a2_reg;
    end

    // Next state and outputs
    always_comb begin
        state_next    = state_reg;
        clr_next      = clr_reg;
        cnt_next      = cnt_reg;
        cmd_pop       = 1'b0;
        m_valid_next  = m_valid_reg && !m_ready;
        m_value_next  = m_value_reg;
        m_status_next = m_status_reg;
        case (state_reg)
            B_CLEAR: begin
                clr_next = clr_reg + MW'(1);
                if (&clr_reg) state_next = B_IDLE;
            end
            B_IDLE: begin
                if (cmd_valid) begin
                    case (cmd_head.act)
                        ACT_CLEAR: begin
                            cmd_pop    = 1'b1;
                            clr_next   = '0;
                            state_next = B_CLEAR;
                        end
                        ACT_DEPOSIT: begin
                            cmd_pop    = 1'b1;
                            cnt_next   = '0;
                            state_next = B_DEPOSIT;
                        end
                        ACT_READ: begin
                            if (!m_valid_reg) begin
                                cmd_pop = 1'b1;
                                if (cmd_head.status) begin
                                    m_valid_next  = 1'b1;
                                    m_value_next  = 40'd0;
                                    m_status_next = 1'b1;
                                end else begin
                                    state_next = B_READ;
                                end
                            end
                        end
                        default: cmd_pop = 1'b1;
                    endcase
                end
            end
            B_DEPOSIT: begin
                cnt_next = cnt_reg + 6'd1;
                if (&cnt_reg) state_next = B_DRAIN;
            end
            B_DRAIN: begin
                if (!v1_reg && !v2_reg && !v3_reg) state_next = B_IDLE;
            end
            B_READ: begin
                m_valid_next  = 1'b1;
                m_value_next  = rdata_reg;
                m_status_next = 1'b0;
                state_next    = B_IDLE;
            end
            default: state_next = B_IDLE;
        endcase
    end

    // A write-back stage always follows a read stage
    a_stage_order: assert property (@(posedge aclk) disable iff (!aresetn)
        v3_reg |-> $past(v2_reg))
        else $error("write-back stage without preceding read stage");

    // No new command starts with deposit updates still in flight
    a_idle_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == B_IDLE) |-> !(v1_reg || v2_reg || v3_reg))
        else $error("back end idle with pipeline busy");

    // A grid read always yields a result on the next cycle
    a_read_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == B_READ) |=> m_valid_reg)
        else $error("grid read produced no result");

endmodule

`default_nettype wire

>>> verif/bspline_charge_spreading_core_tb.sv
// Self-checking testbench for the B-spline charge spreading core.
`timescale 1ns / 100ps
`default_nettype none

module bspline_charge_spreading_core_tb;
    import bcs_pkg::*;

    localparam int  DIM     = 32;
    localparam int  CELLS   = DIM * DIM * DIM;
    localparam longint ONE36  = longint'(1) <<< 36;
    localparam longint SAT_HI = 64'sd549755813887;
    localparam longint SAT_LO = -64'sd549755813888;

    // Grid model plus the queue of read values still owed by the core
    class charge_grid_board;
        longint     grid[CELLS];
        logic [62:0] regs[7];
        logic [39:0] owed_value[$];
        logic        owed_status[$];
        int          errors;

        function new();
            foreach (grid[i]) grid[i] = 0;
            for (int i = 0; i < 7; i++) regs[i] = (i >= 4) ? 63'd32 : 63'd0;
            errors = 0;
        endfunction

        task report(string msg);
            $display("mismatch at %0t: %s", $realtime, msg);
            errors++;
        endtask

        function int pending();
            return owed_value.size();
        endfunction

        function void write_reg(logic [2:0] idx, logic [62:0] d);
            if (idx < REG_SIZE_A) regs[idx] = d;
            else regs[idx] = {57'd0, d[5:0]};
        endfunction

        function longint axis_len(int i);
            longint k;
            k = longint'(regs[REG_SIZE_A + i][5:0]);
            if (k < 4) k = 4;
            if (k > DIM) k = DIM;
            return k;
        endfunction

        function longint field21(logic [62:0] r, int j);
            logic signed [20:0] v;
            v = r[21*j +: 21];
            return longint'(v);
        endfunction

        // q * Mx * My * Mz onto the 4x4x4 neighborhood, saturating
        function void spread(logic signed [31:0] pos[3], logic signed [23:0] q);
            longint p[3], wt[3][4], base[3], kk[3], n[4];
            longint s, x, f, g, t1, t2, t3, v, a, b, c, div, one;
            int idx;
            one = 65536;
            div = 6 * (longint'(1) <<< 24);
            for (int i = 0; i < 3; i++)
                p[i] = longint'(pos[i]) - field21(regs[REG_ORIGIN], i) * 256;
            for (int i = 0; i < 3; i++) begin
                s = 0;
                for (int j = 0; j < 3; j++) s += p[j] * field21(regs[REG_ROW_A + i], j);
                kk[i] = axis_len(i);
                x = kk[i] * (s & (ONE36 - 1)) + 2 * ONE36;
                if (x >= kk[i] * ONE36) x -= kk[i] * ONE36;
                base[i] = (x >>> 36) - 3;
                f = (x & (ONE36 - 1)) >>> 20;
                g = one - f;
                n[0] = g * g * g;
                n[1] = 3 * f * f * f - 6 * f * f * one + 4 * one * one * one;
                n[2] = -3 * f * f * f + 3 * f * f * one + 3 * f * one * one + one * one * one;
                n[3] = f * f * f;
                for (int m = 0; m < 4; m++) wt[i][m] = (n[m] + div / 2) / div;
            end
            for (int j = 0; j < 4; j++) begin
                a = base[0] + j;
                if (a < 0) a += kk[0];
                t1 = (longint'(q) * wt[0][j] + (longint'(1) <<< 15)) >>> 16;
                for (int l = 0; l < 4; l++) begin
                    b = base[1] + l;
                    if (b < 0) b += kk[1];
                    t2 = (t1 * wt[1][l] + (longint'(1) <<< 23)) >>> 24;
                    for (int m = 0; m < 4; m++) begin
                        c = base[2] + m;
                        if (c < 0) c += kk[2];
                        t3 = (t2 * wt[2][m] + (longint'(1) <<< 23)) >>> 24;
                        idx = int'((a * DIM + b) * DIM + c);
                        v = grid[idx] + t3;
                        if (v > SAT_HI) v = SAT_HI;
                        if (v < SAT_LO) v = SAT_LO;
                        grid[idx] = v;
                    end
                end
            end
        endfunction

        // Apply one accepted transaction to the model
        function void note_item(logic [1:0] act, logic signed [31:0] pos[3],
                                logic signed [23:0] q, logic [4:0] ra, logic [4:0] rb,
                                logic [4:0] rc);
            case (action_t'(act))
                ACT_CLEAR: begin
                    foreach (grid[i]) grid[i] = 0;
                end
                ACT_DEPOSIT: spread(pos, q);
                ACT_READ: begin
                    if (ra >= axis_len(0) || rb >= axis_len(1) || rc >= axis_len(2)) begin
                        owed_value.push_back(40'd0);
                        owed_status.push_back(1'b1);
                    end else begin
                        owed_value.push_back(
                            40'(grid[(int'(ra) * DIM + int'(rb)) * DIM + int'(rc)]));
                        owed_status.push_back(1'b0);
                    end
                end
                default: ;
            endcase
        endfunction

        task check_result(logic [39:0] value, logic st);
            logic [39:0] ev;
            logic        es;
            if (owed_value.size() == 0) begin
                report($sformatf("unexpected result value %h status %b", value, st));
            end else begin
                ev = owed_value.pop_front();
                es = owed_status.pop_front();
                if (value !== ev)
                    report($sformatf("grid_value %h, wanted %h", value, ev));
                if (st !== es)
                    report($sformatf("status %b, wanted %b", st, es));
            end
        endtask
    endclass

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [1:0]  s_action = 2'd0;
    logic signed [31:0] s_pos_x = '0, s_pos_y = '0, s_pos_z = '0;
    logic signed [23:0] s_charge = '0;
    logic [4:0]  s_read_a = '0, s_read_b = '0, s_read_c = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic signed [39:0] m_grid_value;
    logic        m_status;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [2:0]  cfg_index = '0;
    logic [62:0] cfg_data = '0;

    charge_grid_board board = new();
    bit calm = 1'b0;
    int stall_left = 0;

    bspline_charge_spreading_core dut (
        .aclk, .aresetn, .s_valid, .s_ready, .s_action, .s_pos_x, .s_pos_y, .s_pos_z,
        .s_charge, .s_read_a, .s_read_b, .s_read_c, .m_valid, .m_ready, .m_grid_value,
        .m_status, .cfg_valid, .cfg_ready, .cfg_index, .cfg_data
    );

    always #10 aclk = ~aclk;

    initial begin
        #60_000_000;
        $display("bspline_charge_spreading_core test failed");
        $finish;
    end

    // Result channel back-pressure: short stalls, rare long ones
    always @(negedge aclk) begin
        if (stall_left > 0) begin
            stall_left--;
            m_ready = 1'b0;
        end else if (calm || $urandom_range(99) < 70) begin
            m_ready = 1'b1;
        end else begin
            m_ready = 1'b0;
            stall_left = ($urandom_range(19) == 0) ? int'($urandom_range(60, 20))
                                                   : int'($urandom_range(2));
        end
    end

    // Result monitor
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) board.check_result(m_grid_value, m_status);
    end

    function automatic int pick_gap();
        int r;
        r = int'($urandom_range(99));
        if (calm || r < 60) return 0;
        if (r < 95) return int'($urandom_range(3, 1));
        return int'($urandom_range(80, 10));
    endfunction

    task automatic send_item(logic [1:0] act, logic [31:0] x, logic [31:0] y,
                             logic [31:0] z, logic [23:0] q, logic [4:0] ra,
                             logic [4:0] rb, logic [4:0] rc);
        logic signed [31:0] pos[3];
        int gap;
        @(negedge aclk);
        s_valid = 1'b1;
        s_action = act;
        s_pos_x = x; s_pos_y = y; s_pos_z = z;
        s_charge = q;
        s_read_a = ra; s_read_b = rb; s_read_c = rc;
        do @(posedge aclk); while (!s_ready);
        pos[0] = x; pos[1] = y; pos[2] = z;
        board.note_item(act, pos, q, ra, rb, rc);
        gap = pick_gap();
        if (gap > 0) begin
            @(negedge aclk);
            s_valid = 1'b0;
            repeat (gap - 1) @(negedge aclk);
        end
    endtask

    task automatic deposit(logic [31:0] x, logic [31:0] y, logic [31:0] z, logic [23:0] q);
        send_item(ACT_DEPOSIT, x, y, z, q, 5'($urandom), 5'($urandom), 5'($urandom));
    endtask

    task automatic read_point(logic [4:0] ra, logic [4:0] rb, logic [4:0] rc);
        send_item(ACT_READ, $urandom, $urandom, $urandom, 24'($urandom), ra, rb, rc);
    endtask

    task automatic clear_grid();
        send_item(ACT_CLEAR, $urandom, $urandom, $urandom, 24'($urandom),
                  5'($urandom), 5'($urandom), 5'($urandom));
    endtask

    // Sender holds off until every result is back and the back end is quiet
    task automatic settle();
        read_point(5'd0, 5'd0, 5'd0);
        @(negedge aclk);
        s_valid = 1'b0;
        while (board.pending() != 0) @(posedge aclk);
        repeat (150) @(posedge aclk);
    endtask

    task automatic cfg_write(logic [2:0] idx, logic [62:0] d);
        @(negedge aclk);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data = d;
        do @(posedge aclk); while (!cfg_ready);
        board.write_reg(idx, d);
        @(negedge aclk);
        cfg_valid = 1'b0;
    endtask

    function automatic logic [62:0] rand63();
        return 63'({$urandom, $urandom});
    endfunction

    function automatic logic [62:0] rand_size();
        case ($urandom_range(5))
            0: return 63'd4;
            1: return 63'd32;
            2: return 63'($urandom_range(3));
            3: return 63'($urandom_range(63, 33));
            default: return 63'($urandom_range(32, 4));
        endcase
    endfunction

    // Random item: mostly deposits and reads, some ignored actions
    task automatic random_item();
        int r;
        logic [4:0] ra, rb, rc;
        r = int'($urandom_range(99));
        if (r < 4) begin
            send_item(ACT_NOP, $urandom, $urandom, $urandom, 24'($urandom),
                      5'($urandom), 5'($urandom), 5'($urandom));
        end else if (r < 50) begin
            deposit($urandom, $urandom, $urandom, 24'($urandom));
        end else begin
            ra = 5'($urandom_range(32'(board.axis_len(0) - 1)));
            rb = 5'($urandom_range(32'(board.axis_len(1) - 1)));
            rc = 5'($urandom_range(32'(board.axis_len(2) - 1)));
            if ($urandom_range(9) == 0) begin
                case ($urandom_range(2))
                    0: ra = 5'($urandom);
                    1: rb = 5'($urandom);
                    default: rc = 5'($urandom);
                endcase
            end
            read_point(ra, rb, rc);
        end
    endtask

    initial begin
        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // Directed: extreme settings and field values
        cfg_write(REG_ORIGIN, {3{21'h0FFFFF}});
        cfg_write(REG_ROW_A, {21'h100000, 21'h100000, 21'h0FFFFF});
        cfg_write(REG_ROW_B, {21'h0FFFFF, 21'h000000, 21'h100000});
        cfg_write(REG_ROW_C, {21'h000001, 21'h1FFFFF, 21'h0FFFFF});
        read_point(5'd0, 5'd0, 5'd0);
        read_point(5'd31, 5'd31, 5'd31);
        deposit(32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 24'h7FFFFF);
        deposit(32'h80000000, 32'h80000000, 32'h80000000, 24'h800000);
        deposit(32'h0, 32'h0, 32'h0, 24'h0);
        deposit(32'hFFFFFFFF, 32'h00010000, 32'h00008000, 24'hFFFFFF);
        send_item(ACT_NOP, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 24'hFFFFFF,
                  5'd31, 5'd31, 5'd31);
        for (int i = 0; i < 4; i++) read_point(5'($urandom), 5'($urandom), 5'($urandom));
        settle();
        cfg_write(REG_SIZE_A, 63'd0);
        cfg_write(REG_SIZE_B, 63'd63);
        cfg_write(REG_SIZE_C, 63'd4);
        deposit(32'h12345678, 32'h9ABCDEF0, 32'h0F0F0F0F, 24'h7FFFFF);
        read_point(5'd3, 5'd31, 5'd3);
        read_point(5'd4, 5'd0, 5'd0);
        read_point(5'd0, 5'd0, 5'd4);
        read_point(5'd2, 5'd1, 5'd2);
        clear_grid();
        read_point(5'd3, 5'd3, 5'd3);
        settle();

        // Pile charge on one neighborhood until the accumulators saturate
        for (int i = 0; i < 4; i++) cfg_write(3'(REG_ORIGIN + i), 63'd0);
        for (int i = 0; i < 3; i++) cfg_write(3'(REG_SIZE_A + i), 63'd4);
        for (int i = 0; i < 900; i++) deposit($urandom, $urandom, $urandom, 24'h7FFFFF);
        for (int i = 0; i < 64; i++) read_point(5'(i[5:4]), 5'(i[3:2]), 5'(i[1:0]));
        settle();

        // Random phases with varied settings
        for (int ph = 0; ph < 5; ph++) begin
            calm = (ph == 2);
            cfg_write(REG_ORIGIN, rand63());
            for (int i = 0; i < 3; i++)
                cfg_write(3'(REG_ROW_A + i), (ph == 4) ? {3{21'h100000}} : rand63());
            for (int i = 0; i < 3; i++)
                cfg_write(3'(REG_SIZE_A + i), (ph == 0) ? 63'd32 : rand_size());
            if (ph == 1 || ph == 3) clear_grid();
            for (int i = 0; i < 160; i++) random_item();
            settle();
        end
        calm = 1'b0;

        @(negedge aclk);
        s_valid = 1'b0;
        while (board.pending() != 0) @(posedge aclk);
        repeat (200) @(posedge aclk);
        if (board.errors == 0 && board.pending() == 0) begin
            $display("bspline_charge_spreading_core test passed");
        end else begin
            $display("bspline_charge_spreading_core test failed");
        end
        $finish;
    end

endmodule

`default_nettype wire

>>> filelist.f
src/bcs_pkg.sv
src/bcs_front.sv
src/bcs_cmd_fifo.sv
src/bcs_back.sv
src/bspline_charge_spreading_core.sv
verif/bspline_charge_spreading_core_tb.sv
